[hw/rtl/thm_pkg.sv]
// Shared constants and the fixed resistance curve for the thermistor table interpolator.
// Used by thermistor_table_interpolator and tb_top; depends on nothing.
`default_nettype none

package thm_pkg;

  // Fixed field widths of the stream payload.
  localparam int RES_W  = 28;
  localparam int TEMP_W = 12;

  // Stream bus widths, fields padded to whole bytes.
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 16;

  // Curve geometry: entry k stands for k*STEP_DEG - BASE_DEG degrees.
  localparam int CURVE_FIXED_POINTS = 33;
  localparam int STEP_DEG           = 5;
  localparam int BASE_DEG           = 55;

  // Defaults for the top-level parameters.
  localparam int TABLE_POINTS_DEF   = 33;
  localparam int RES_FRAC_BITS_DEF  = 4;
  localparam int TEMP_FRAC_BITS_DEF = 4;

  // Curve entry k in ohms with frac fraction bits, rounded half up.
  // Entries past the fixed curve read as zero. Called with constants only.
  function automatic logic [RES_W-1:0] curve_entry(input int unsigned k,
                                                   input int unsigned frac);
    logic [63:0] mohm;
    logic [63:0] v;
    case (k)
      0:       mohm = 64'd437139000;
      1:       mohm = 64'd326906000;
      2:       mohm = 64'd246574000;
      3:       mohm = 64'd187518000;
      4:       mohm = 64'd143739000;
      5:       mohm = 64'd111025000;
      6:       mohm = 64'd86390000;
      7:       mohm = 64'd67699600;
      8:       mohm = 64'd53417700;
      9:       mohm = 64'd42428700;
      10:      mohm = 64'd33916400;
      11:      mohm = 64'd27280000;
      12:      mohm = 64'd22073400;
      13:      mohm = 64'd17963800;
      14:      mohm = 64'd14701000;
      15:      mohm = 64'd12095700;
      16:      mohm = 64'd10000000;
      17:      mohm = 64'd8313000;
      18:      mohm = 64'd6946070;
      19:      mohm = 64'd5829240;
      20:      mohm = 64'd4914200;
      21:      mohm = 64'd4161000;
      22:      mohm = 64'd3538180;
      23:      mohm = 64'd3020930;
      24:      mohm = 64'd2589510;
      25:      mohm = 64'd2228220;
      26:      mohm = 64'd1924430;
      27:      mohm = 64'd1668020;
      28:      mohm = 64'd1451000;
      29:      mohm = 64'd1266060;
      30:      mohm = 64'd1108440;
      31:      mohm = 64'd973500;
      32:      mohm = 64'd857575;
      default: mohm = 64'd0;
    endcase
    v = ((mohm << frac) + 64'd500) / 64'd1000;
    return v[RES_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/thermistor_table_interpolator.sv]
// Top level of the thermistor table interpolator: curve memory, bisection sequencer, output.
// Depends on thm_pkg and thm_div.
`default_nettype none

// Channel  Dir  Bits  Contents
// s_*      in   32    tdata[27:0] resistance, unsigned, RES_FRAC_BITS fraction bits
// m_*      out  16    tdata[11:0] temperature, signed, TEMP_FRAC_BITS fraction bits;
//                     tuser[0] out_of_range
//
// For an item in range m_tvalid rises once the bisection probes and the division are done;
// there are at most ceil(log2(TABLE_POINTS-1)) probes. An item out of range skips both,
// and an exact probe hit or a flat bracket skips the divider. The single read port of the
// curve memory means each probe passes through ST_PROBE and then ST_CMP, and the divider
// yields one quotient bit per cycle.
// After reset the load sweep writes every curve memory entry while s_tready is low.
// A finished result waits in the output register; one further item may be accepted and
// worked on meanwhile, and it holds in its last step until the output register is free.
module thermistor_table_interpolator #(
  parameter int TABLE_POINTS   = thm_pkg::TABLE_POINTS_DEF,
  parameter int RES_FRAC_BITS  = thm_pkg::RES_FRAC_BITS_DEF,
  parameter int TEMP_FRAC_BITS = thm_pkg::TEMP_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [thm_pkg::S_DATA_W-1:0]  s_tdata,  // [27:0] resistance
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [thm_pkg::M_DATA_W-1:0]       m_tdata,  // [11:0] temperature
  output logic                               m_tuser   // [0] out_of_range
);

  localparam int RES_W  = thm_pkg::RES_W;
  localparam int TEMP_W = thm_pkg::TEMP_W;
  localparam int IW     = $clog2(TABLE_POINTS);
  // The fraction is at most STEP_DEG * 2^TEMP_FRAC_BITS, which fits in KW bits.
  localparam int KW     = TEMP_FRAC_BITS + 3;
  localparam int NUM_W  = RES_W + KW;
  // Signed width for point temperature plus fraction before saturation.
  localparam int PW     = TEMP_FRAC_BITS + 14;

  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_POINTS - 1);
  localparam logic [KW-1:0] KSTEP    = KW'(thm_pkg::STEP_DEG << TEMP_FRAC_BITS);
  localparam logic signed [PW-1:0] T_MAX = PW'((2 ** (TEMP_W - 1)) - 1);
  localparam logic signed [PW-1:0] T_MIN = PW'(-(2 ** (TEMP_W - 1)));

  typedef enum logic [8:0] {
    ST_FILL  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_FIRST = 9'b000000100,
    ST_LAST  = 9'b000001000,
    ST_PROBE = 9'b000010000,
    ST_CMP   = 9'b000100000,
    ST_MUL   = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state;

  // Constant curve values, written into the memory by the load sweep after reset.
  logic [RES_W-1:0] curve_const [TABLE_POINTS];
  for (genvar k = 0; k < TABLE_POINTS; k++) begin : g_curve
    assign curve_const[k] = thm_pkg::curve_entry(k, RES_FRAC_BITS);
  end

  logic [RES_W-1:0] mem [TABLE_POINTS];
  logic [RES_W-1:0] rdata;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    fill_idx;

  // Item context.
  logic [RES_W-1:0] r_q;
  logic [RES_W-1:0] lo_val;
  logic [RES_W-1:0] hi_val;
  logic [IW-1:0]    bot_idx;
  logic [IW-1:0]    top_idx;
  logic [IW-1:0]    probe_idx;
  logic [KW-1:0]    frac_q;
  logic             oor_q;

  logic [IW:0]      idx_sum;
  logic [IW-1:0]    probe_next;
  logic [IW-1:0]    bot_next;
  logic [IW-1:0]    top_next;
  logic             more_probes;

  logic             div_start;
  logic             div_done;
  logic [KW-1:0]    div_quot;
  logic [RES_W-1:0] lo_minus_r;
  logic [RES_W-1:0] den_w;
  logic [NUM_W-1:0] num_w;

  logic signed [PW-1:0] base_deg;
  logic signed [PW-1:0] temp_sum;
  logic [TEMP_W-1:0]    temp_sat;
  logic                 out_free;

  // Curve memory with a single read port: load sweep writes, registered read.
  always_ff @(posedge clk) begin
    if (state == ST_FILL) begin
      mem[fill_idx] <= curve_const[fill_idx];
    end
    rdata <= mem[rd_addr];
  end

  assign idx_sum    = {1'b0, top_idx} + {1'b0, bot_idx};
  assign probe_next = idx_sum[IW:1];

  always_comb begin
    case (state)
      ST_IDLE:  rd_addr = '0;
      ST_FIRST: rd_addr = LAST_IDX;
      ST_PROBE: rd_addr = probe_next;
      default:  rd_addr = probe_idx;
    endcase
  end

  // Bracket update from the probe that has just been read.
  always_comb begin
    bot_next = bot_idx;
    top_next = top_idx;
    if (r_q > rdata) begin
      top_next = probe_idx;
    end else begin
      bot_next = probe_idx;
    end
  end
  assign more_probes = {1'b0, top_next} > ({1'b0, bot_next} + (IW + 1)'(1));

  // Interpolation numerator and denominator; the bracket keeps both non-negative.
  assign lo_minus_r = lo_val - r_q;
  assign den_w      = lo_val - hi_val;
  assign num_w      = lo_minus_r * KSTEP;
  assign div_start  = (state == ST_MUL) && (den_w != '0);

  thm_div #(
    .NUM_W(NUM_W),
    .DEN_W(RES_W),
    .Q_W  (KW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (num_w),
    .den     (den_w),
    .done    (div_done),
    .quotient(div_quot)
  );

  // Point temperature of the lower bracket entry plus the truncated fraction.
  assign base_deg = $signed(PW'(bot_idx) * PW'(thm_pkg::STEP_DEG))
                    - $signed(PW'(thm_pkg::BASE_DEG));
  assign temp_sum = (base_deg <<< TEMP_FRAC_BITS) + $signed(PW'(frac_q));

  always_comb begin
    if (temp_sum > T_MAX) begin
      temp_sat = T_MAX[TEMP_W-1:0];
    end else if (temp_sum < T_MIN) begin
      temp_sat = T_MIN[TEMP_W-1:0];
    end else begin
      temp_sat = temp_sum[TEMP_W-1:0];
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      fill_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The output register is loaded when it is empty or its item is being taken.
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_FILL: begin
          fill_idx <= fill_idx + IW'(1);
          if (fill_idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_FIRST;
          end
        end
        ST_FIRST: state <= ST_LAST;
        ST_LAST: begin
          if (r_q > lo_val || r_q < rdata) begin
            state <= ST_OUT;
          end else begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: state <= ST_CMP;
        ST_CMP: begin
          if (r_q == rdata) begin
            state <= ST_OUT;
          end else if (more_probes) begin
            state <= ST_PROBE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (div_start) begin
            state <= ST_DIV;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

  // Item context and output payload.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        r_q    <= s_tdata[RES_W-1:0];
        oor_q  <= 1'b0;
        frac_q <= '0;
      end
      ST_FIRST: lo_val <= rdata;
      ST_LAST: begin
        hi_val  <= rdata;
        bot_idx <= '0;
        top_idx <= LAST_IDX;
        oor_q   <= (r_q > lo_val) || (r_q < rdata);
      end
      ST_PROBE: probe_idx <= probe_next;
      ST_CMP: begin
        // An exact hit leaves the fraction at zero and takes the probe as the point.
        bot_idx <= bot_next;
        top_idx <= top_next;
        if (r_q > rdata) begin
          hi_val <= rdata;
        end else begin
          lo_val <= rdata;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          frac_q <= div_quot;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= {{(thm_pkg::M_DATA_W - TEMP_W){1'b0}},
                      (oor_q ? {TEMP_W{1'b0}} : temp_sat)};
          m_tuser <= oor_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/thm_div.sv]
// Restoring serial divider for the interpolation fraction, one quotient bit per cycle.
// Depends on nothing; instantiated by thermistor_table_interpolator.
`default_nettype none

module thm_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 28,
  parameter int Q_W   = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [Q_W-1:0]        quotient
);

  // The caller guarantees num < den * 2^Q_W, so only Q_W steps are needed.
  localparam int SW = DEN_W + Q_W - 1;
  localparam int CW = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [NUM_W-1:0] rem;
  logic [SW-1:0]    dsh;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             fits;

  assign fits = rem >= NUM_W'(dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num;
      dsh      <= SW'(den) << (Q_W - 1);
      cnt      <= CW'(Q_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - NUM_W'(dsh);
      end
      quotient <= {quotient[Q_W-2:0], fits};
      dsh      <= dsh >> 1;
      cnt      <= cnt - CW'(1);
    end
  end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the thermistor table interpolator: directed and random items.
// Depends on thm_pkg and the thermistor_table_interpolator RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;

  localparam int RES_W          = thm_pkg::RES_W;
  localparam int TEMP_W         = thm_pkg::TEMP_W;
  localparam int S_DATA_W       = thm_pkg::S_DATA_W;
  localparam int M_DATA_W       = thm_pkg::M_DATA_W;
  localparam int STEP_DEG       = thm_pkg::STEP_DEG;
  localparam int BASE_DEG       = thm_pkg::BASE_DEG;
  localparam int POINTS         = thm_pkg::TABLE_POINTS_DEF;
  localparam int RES_FRAC       = thm_pkg::RES_FRAC_BITS_DEF;
  localparam int TEMP_FRAC      = thm_pkg::TEMP_FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS   = 1875;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam longint TEMP_MAX   = 2047;
  localparam longint TEMP_MIN   = -2048;

  // Curve points in milliohms, highest resistance (coldest point) first.
  localparam longint unsigned CURVE_MOHM [POINTS] = '{
    437139000, 326906000, 246574000, 187518000, 143739000, 111025000,
    86390000, 67699600, 53417700, 42428700, 33916400, 27280000,
    22073400, 17963800, 14701000, 12095700, 10000000, 8313000,
    6946070, 5829240, 4914200, 4161000, 3538180, 3020930,
    2589510, 2228220, 1924430, 1668020, 1451000, 1266060,
    1108440, 973500, 857575
  };

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } reading_t;

  // One directed item. Where known is set, temp and oor hold the expected
  // result; otherwise the item is checked against the predictor.
  typedef struct packed {
    logic [RES_W-1:0]         res;
    logic                     known;
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{28'd0,          1'b1, 12'sd0,    1'b1},  // far below the hottest entry
    '{28'd13720,      1'b1, 12'sd0,    1'b1},  // one below the last entry
    '{28'd13721,      1'b1, 12'sd1680, 1'b0},  // equal to the last entry
    '{28'd13722,      1'b0, 12'sd0,    1'b0},
    '{28'd6994224,    1'b1, -12'sd880, 1'b0},  // equal to the first entry
    '{28'd6994225,    1'b1, 12'sd0,    1'b1},  // one above the first entry
    '{28'd6994223,    1'b0, 12'sd0,    1'b0},
    '{28'hFFFFFFF,    1'b1, 12'sd0,    1'b1},  // all ones
    '{28'h8000000,    1'b1, 12'sd0,    1'b1},
    '{28'hAAAAAAA,    1'b1, 12'sd0,    1'b1},
    '{28'h5555555,    1'b1, 12'sd0,    1'b1},
    '{28'd160000,     1'b1, 12'sd400,  1'b0},  // first probe hits exactly: 25 degrees
    '{28'd159999,     1'b0, 12'sd0,    1'b0},
    '{28'd160001,     1'b0, 12'sd0,    1'b0},
    '{28'd854683,     1'b0, 12'sd0,    1'b0},  // second probe hits exactly
    '{28'd5000000,    1'b0, 12'sd0,    1'b0},
    '{28'd2000000,    1'b0, 12'sd0,    1'b0},
    '{28'd1000000,    1'b0, 12'sd0,    1'b0},
    '{28'd500000,     1'b0, 12'sd0,    1'b0},
    '{28'd250000,     1'b0, 12'sd0,    1'b0},
    '{28'd100000,     1'b0, 12'sd0,    1'b0},
    '{28'd50000,      1'b0, 12'sd0,    1'b0},
    '{28'd30000,      1'b0, 12'sd0,    1'b0},
    '{28'd20000,      1'b0, 12'sd0,    1'b0},
    '{28'd15000,      1'b0, 12'sd0,    1'b0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;

  // Expected result carried alongside the item being offered.
  logic                     offer_known = 1'b0;
  logic signed [TEMP_W-1:0] offer_temp = '0;
  logic                     offer_oor = 1'b0;

  logic [RES_W-1:0] curve_res [POINTS];
  reading_t         expected_readings [$];
  int unsigned      mismatches = 0;
  int unsigned      results_seen = 0;
  int unsigned      quiet_cycles = 0;
  bit               steady = 1'b0;     // both sides stop idling while set
  bit               hold_request = 1'b0;

  always #4 clk = ~clk;

  thermistor_table_interpolator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [27:0] resistance
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [11:0] temperature
    .m_tuser  (m_tuser)    // [0] out_of_range
  );

  // Curve in ohms with RES_FRAC fraction bits, rounded half up.
  initial begin
    for (int k = 0; k < POINTS; k++) begin
      curve_res[k] = RES_W'(((CURVE_MOHM[k] << RES_FRAC) + 500) / 1000);
    end
  end

  function automatic longint point_temp(input int unsigned idx);
    return (longint'(idx) * STEP_DEG - BASE_DEG) * (longint'(1) << TEMP_FRAC);
  endfunction

  // Bisect the curve for the bracketing pair, then interpolate linearly.
  function automatic reading_t thermistor_temperature(input logic [RES_W-1:0] res);
    reading_t    rd;
    int unsigned lo;
    int unsigned hi;
    int unsigned probe;
    longint      num;
    longint      den;
    longint      t;
    bit          hit;
    rd.temp = '0;
    rd.oor  = 1'b0;
    if (res > curve_res[0] || res < curve_res[POINTS-1]) begin
      rd.oor = 1'b1;
      return rd;
    end
    lo  = 0;
    hi  = POINTS - 1;
    hit = 1'b0;
    t   = 0;
    while (!hit && hi - lo > 1) begin
      probe = (lo + hi) / 2;
      if (res > curve_res[probe]) begin
        hi = probe;
      end else if (res < curve_res[probe]) begin
        lo = probe;
      end else begin
        hit = 1'b1;
        t   = point_temp(probe);
      end
    end
    if (!hit) begin
      num = (longint'(curve_res[lo]) - longint'(res)) * (longint'(STEP_DEG) << TEMP_FRAC);
      den = longint'(curve_res[lo]) - longint'(curve_res[hi]);
      t   = point_temp(lo) + ((den == 0) ? 0 : num / den);
    end
    if (t > TEMP_MAX) t = TEMP_MAX;
    if (t < TEMP_MIN) t = TEMP_MIN;
    rd.temp = t[TEMP_W-1:0];
    return rd;
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Resistance for the random part. Most items land between two curve points or
  // on or beside one, so every segment of the curve is exercised, not just the cold end.
  function automatic logic [RES_W-1:0] random_resistance();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(99);
    if (pick < 45) begin
      k = $urandom_range(POINTS - 2);
      return RES_W'($urandom_range(curve_res[k], curve_res[k+1]));
    end else if (pick < 60) begin
      k = $urandom_range(POINTS - 1);
      return RES_W'(curve_res[k] + $urandom_range(2) - 1);
    end else if (pick < 75) begin
      return RES_W'($urandom_range(curve_res[0], curve_res[POINTS-1]));
    end else if (pick < 87) begin
      return RES_W'($urandom_range({RES_W{1'b1}}, curve_res[0] + 1));
    end else if (pick < 95) begin
      return RES_W'($urandom_range(curve_res[POINTS-1] - 1, 0));
    end
    return RES_W'($urandom());
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input logic [RES_W-1:0] res, input logic known,
                           input logic signed [TEMP_W-1:0] temp, input logic oor);
    while (!steady && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= S_DATA_W'(res);
    offer_known <= known;
    offer_temp  <= temp;
    offer_oor   <= oor;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_pending();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 17);
        @(posedge clk);
      end
    end
  end

  // Everything is sampled at the rising edge, before this edge's updates land.
  always @(posedge clk) begin : monitor
    reading_t got;
    reading_t want;
    reading_t model;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.temp = m_tdata[TEMP_W-1:0];
        got.oor  = m_tuser;
        results_seen++;
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending: temp %0d oor %0b",
                                    results_seen, got.temp, got.oor));
        end else begin
          want = expected_readings.pop_front();
          if (got.temp !== want.temp) begin
            report_mismatch($sformatf("result %0d: temperature expected %0d got %0d",
                                      results_seen, want.temp, got.temp));
          end
          if (got.oor !== want.oor) begin
            report_mismatch($sformatf("result %0d: out_of_range expected %0b got %0b",
                                      results_seen, want.oor, got.oor));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (offer_known) begin
          model.temp = offer_temp;
          model.oor  = offer_oor;
        end else begin
          model = thermistor_temperature(s_tdata[RES_W-1:0]);
        end
        expected_readings.push_back(model);
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(DIRECTED[i].res, DIRECTED[i].known, DIRECTED[i].temp, DIRECTED[i].oor);
    end
    drain_pending();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 600 && i < 900);
      // Receiver stalls for a long stretch while items keep coming, filling the block.
      if (i == 1100) hold_request = 1'b1;
      // Sender stops until every outstanding result is back.
      if (i == 1500) drain_pending();
      send_item(random_resistance(), 1'b0, '0, 1'b0);
    end
    steady = 1'b0;
    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
